@@ rtl/core/pba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;

    localparam int DEF_NUM_PAGES = 4096;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_MARK  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_TOTAL_PAGES = 3'd0;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] base_page;
        logic [12:0] span;
    } pba_in_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] alloc_base;
        logic        any_used;
        logic [12:0] used_pages;
    } pba_out_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic eval;
        logic finish;
        logic ok;
        logic any;
    } pba_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] mode;
        logic       at_end;
        logic       alloc_bad;
        logic       hit;
        logic       no_room;
        logic       slot_free;
    } pba_status_t;

endpackage
`default_nettype wire

@@ rtl/core/pba_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pba_datapath #(
    parameter int NUM_PAGES = pba_pkg::DEF_NUM_PAGES
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire pba_pkg::pba_cmd_t      cmd,
    output pba_pkg::pba_status_t        st,
    input  wire pba_pkg::pba_in_t       in_item,
    output logic                        out_valid,
    input  wire                         out_ready,
    output pba_pkg::pba_out_t           out_item,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [pba_pkg::PADDR_W-1:0]  paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata
);
    import pba_pkg::*;

    localparam int PW = $clog2(NUM_PAGES);
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int XW = (CW > 14) ? CW : 14;
    localparam logic [XW-1:0] NUM_X = XW'(NUM_PAGES);

    logic          mem [NUM_PAGES];
    logic          rd_bit_reg;
    logic [PW-1:0] clr_addr_reg;

    logic [12:0]   total_reg;
    logic [1:0]    mode_reg, mode_next;
    logic [XW-1:0] cursor_reg, cursor_next;
    logic [XW-1:0] limit_reg, limit_next;
    logic [XW-1:0] len_reg, len_next;
    logic [XW-1:0] start_reg, start_next;
    logic [XW-1:0] need_reg;
    logic [XW-1:0] tmn_reg;
    logic [XW-1:0] abase_reg, abase_next;
    logic [CW-1:0] hint_reg, hint_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    pba_out_t      out_reg;

    logic [XW-1:0] managed;
    logic [XW-1:0] range_end;
    logic [XW-1:0] cursor_inc;
    logic          we;
    logic          wbit;
    logic [PW-1:0] waddr;
    logic          reg_sel;

    assign managed    = (XW'(total_reg) < NUM_X) ? XW'(total_reg) : NUM_X;
    assign range_end  = XW'(in_item.base_page) + XW'(in_item.span);
    assign cursor_inc = cursor_reg + XW'(1);
    assign reg_sel    = (paddr[PADDR_W-1:2] == ADDR_TOTAL_PAGES[PADDR_W-1:2]);

    assign st.clr_last  = (clr_addr_reg == PW'(NUM_PAGES - 1));
    assign st.mode      = mode_reg;
    assign st.at_end    = (cursor_reg >= limit_reg);
    assign st.alloc_bad = (need_reg == '0) || (need_reg > managed);
    assign st.hit       = rd_bit_reg;
    assign st.no_room   = cursor_inc > tmn_reg;
    assign st.slot_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign prdata    = reg_sel ? 32'(total_reg) : 32'd0;

    always_comb
    begin
        mode_next   = mode_reg;
        cursor_next = cursor_reg;
        limit_next  = limit_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        abase_next  = abase_reg;
        hint_next   = hint_reg;
        count_next  = count_reg;
        we          = 1'b0;
        wbit        = 1'b0;
        waddr       = cursor_reg[PW-1:0];
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
        end
        else if (cmd.eval)
        begin
            unique case (mode_reg)
                OP_MARK:
                begin
                    cursor_next = cursor_inc;
                    if (!rd_bit_reg)
                    begin
                        we         = 1'b1;
                        wbit       = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (cursor_reg == XW'(hint_reg))
                            hint_next = hint_reg + CW'(1);
                    end
                end
                OP_FREE:
                begin
                    cursor_next = cursor_inc;
                    if (rd_bit_reg)
                    begin
                        we         = 1'b1;
                        count_next = count_reg - CW'(1);
                        if (cursor_reg < XW'(hint_reg))
                            hint_next = CW'(cursor_reg);
                    end
                end
                OP_QUERY:
                    cursor_next = cursor_inc;
                OP_ALLOC:
                begin
                    if (rd_bit_reg)
                    begin
                        len_next    = '0;
                        start_next  = cursor_inc;
                        cursor_next = cursor_inc;
                    end
                    else if (len_reg + XW'(1) == need_reg)
                    begin
                        mode_next   = OP_MARK;
                        cursor_next = start_reg;
                        limit_next  = start_reg + need_reg;
                        abase_next  = start_reg;
                    end
                    else
                    begin
                        len_next    = len_reg + XW'(1);
                        cursor_next = cursor_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wbit;
        rd_bit_reg <= mem[cursor_reg[PW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            total_reg     <= '0;
            hint_reg      <= '0;
            count_reg     <= '0;
            mode_reg      <= OP_ALLOC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_addr_reg <= clr_addr_reg + PW'(1);
            if (psel && penable && pwrite && reg_sel)
                total_reg <= pwdata[12:0];
            hint_reg  <= hint_next;
            count_reg <= count_next;
            if (cmd.load)
                mode_reg <= in_item.opcode;
            else
                mode_reg <= mode_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_reg   <= '0;
            start_reg <= XW'(hint_reg);
            need_reg  <= XW'(in_item.span);
            tmn_reg   <= managed - XW'(in_item.span);
            abase_reg <= '0;
            if (in_item.opcode == OP_ALLOC)
            begin
                cursor_reg <= XW'(hint_reg);
                limit_reg  <= managed;
            end
            else
            begin
                cursor_reg <= XW'(in_item.base_page);
                limit_reg  <= (range_end < NUM_X) ? range_end : NUM_X;
            end
        end
        else
        begin
            cursor_reg <= cursor_next;
            limit_reg  <= limit_next;
            len_reg    <= len_next;
            start_reg  <= start_next;
            abase_reg  <= abase_next;
        end
        if (cmd.finish)
        begin
            out_reg.ok         <= cmd.ok;
            out_reg.alloc_base <= cmd.ok ? abase_reg[11:0] : 12'd0;
            out_reg.any_used   <= cmd.any;
            out_reg.used_pages <= 13'(count_reg);
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= NUM_X)
        else $error("used count beyond page total");

    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(hint_reg) <= NUM_X)
        else $error("search hint beyond page total");

    a_finish_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwrites a pending item");

    a_no_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !cmd.load && !cmd.eval)
        else $error("work during clearing pass");

endmodule
`default_nettype wire

@@ rtl/core/pba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pba_ctrl (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_ready,
    output pba_pkg::pba_cmd_t         cmd,
    input  wire pba_pkg::pba_status_t st
);
    import pba_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (st.mode == OP_ALLOC && (st.alloc_bad || st.at_end))
                begin
                    if (st.slot_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (st.at_end)
                begin
                    if (st.slot_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.ok     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (st.mode == OP_QUERY && st.hit)
                begin
                    if (st.slot_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.ok     = 1'b1;
                        cmd.any    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (st.mode == OP_ALLOC && st.hit && st.no_room)
                begin
                    if (st.slot_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.eval   = 1'b1;
                    state_next = S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_READ)
        else $error("load did not start a pass");

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> $past(state_reg) == S_READ)
        else $error("evaluation without a read");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !in_ready)
        else $error("finish while idle");

endmodule
`default_nettype wire

@@ rtl/core/page_bitmap_allocator_top.sv @@
// First-fit page allocator over a one-bit-per-page used map held in a memory with one write
// port and a registered read port. Every page visited passes a read state, then an update
// state; free, mark-used and query walk their range (query stops at the first used page);
// allocate scans pages from the search hint up to the end of the run found, then marks
// each page of the run. One item is in flight at a time; its result waits in an output
// register while the next item is taken. After reset a clearing pass over all NUM_PAGES
// pages runs before the first item is accepted; total_pages may be written during it.
`timescale 1ns / 1ps
`default_nettype none
module page_bitmap_allocator_top #(
    parameter int NUM_PAGES = pba_pkg::DEF_NUM_PAGES
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire pba_pkg::pba_in_t       in_item,
    output logic                        out_valid,
    input  wire                         out_ready,
    output pba_pkg::pba_out_t           out_item,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [pba_pkg::PADDR_W-1:0]  paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pba_pkg::*;

    pba_cmd_t    cmd;
    pba_status_t st;

    assign pready = 1'b1;

    pba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .st       (st)
    );

    pba_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata)
    );

endmodule
`default_nettype wire

@@ tb/sv/page_bitmap_allocator_top_tb.sv @@
`timescale 1ns / 1ps
module page_bitmap_allocator_top_tb;
    import pba_pkg::*;

    localparam int NPAGES = DEF_NUM_PAGES;
    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_LEN = 300;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    pba_in_t in_item;
    logic out_valid;
    logic out_ready;
    pba_out_t out_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    page_bitmap_allocator_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // allocator shadow state
    bit page_map [NPAGES];
    int unsigned hint;
    int unsigned used_cnt;
    int unsigned managed;

    pba_in_t request_q[$];
    pba_out_t expected_q[$];
    int unsigned n_errors;
    int unsigned n_sent;
    int unsigned n_checked;
    int unsigned n_alloc_fail;
    int unsigned idle_cycles;
    int unsigned gap_left;
    int unsigned stall_left;
    bit hold_off;
    bit hold_done;
    int unsigned hold_cycles;

    function automatic void mark_pages(int unsigned b, int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (b + i >= NPAGES)
                break;
            if (!page_map[b + i]) begin
                used_cnt++;
                if (b + i == hint)
                    hint++;
                page_map[b + i] = 1'b1;
            end
        end
    endfunction

    function automatic void free_pages(int unsigned b, int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (b + i >= NPAGES)
                break;
            if (page_map[b + i]) begin
                used_cnt--;
                if (b + i < hint)
                    hint = b + i;
                page_map[b + i] = 1'b0;
            end
        end
    endfunction

    function automatic bit range_used(int unsigned b, int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (b + i >= NPAGES)
                break;
            if (page_map[b + i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit first_fit(int unsigned n, output int unsigned at);
        int unsigned tot;
        int unsigned run;
        int unsigned start;
        tot = managed;
        run = 0;
        at = 0;
        if (n == 0 || n > tot)
            return 1'b0;
        start = hint;
        for (int unsigned p = hint; p < tot; p++) begin
            if (page_map[p]) begin
                run = 0;
                start = p + 1;
                if (start > tot - n)
                    return 1'b0;
            end
            else begin
                run++;
                if (run == n) begin
                    at = start;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic pba_out_t apply_request(pba_in_t r);
        pba_out_t o;
        int unsigned at;
        o = '0;
        o.ok = 1'b1;
        case (r.opcode)
            OP_ALLOC:
            begin
                if (first_fit(r.span, at)) begin
                    mark_pages(at, r.span);
                    o.alloc_base = at[11:0];
                end
                else begin
                    o.ok = 1'b0;
                    n_alloc_fail++;
                end
            end
            OP_FREE: free_pages(r.base_page, r.span);
            OP_MARK: mark_pages(r.base_page, r.span);
            default: o.any_used = range_used(r.base_page, r.span);
        endcase
        o.used_pages = used_cnt[12:0];
        return o;
    endfunction

    function automatic pba_in_t make_req(logic [1:0] op, int unsigned b, int unsigned n);
        pba_in_t r;
        r.opcode = op;
        r.base_page = b[11:0];
        r.span = n[12:0];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(0, 4);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item <= '0;
            gap_left <= 0;
        end
        else if (in_valid && !in_ready) begin
        end
        else begin
            if (in_valid && in_ready) begin
                expected_q.push_back(apply_request(in_item));
                n_sent++;
            end
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (request_q.size() != 0) begin
                in_item <= request_q.pop_front();
                in_valid <= 1'b1;
                gap_left <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected item %p", $time, out_item);
                    n_errors++;
                end
                else begin
                    pba_out_t e;
                    e = expected_q.pop_front();
                    n_checked++;
                    if (e.ok !== out_item.ok) begin
                        $display("%0t: ok exp %0d got %0d", $time, e.ok, out_item.ok);
                        n_errors++;
                    end
                    if (e.alloc_base !== out_item.alloc_base) begin
                        $display("%0t: alloc_base exp %0d got %0d", $time,
                                 e.alloc_base, out_item.alloc_base);
                        n_errors++;
                    end
                    if (e.any_used !== out_item.any_used) begin
                        $display("%0t: any_used exp %0d got %0d", $time,
                                 e.any_used, out_item.any_used);
                        n_errors++;
                    end
                    if (e.used_pages !== out_item.used_pages) begin
                        $display("%0t: used_pages exp %0d got %0d", $time,
                                 e.used_pages, out_item.used_pages);
                        n_errors++;
                    end
                end
            end
            if (hold_off && !hold_done) begin
                out_ready <= 1'b0;
                hold_cycles <= hold_cycles + 1;
                if (hold_cycles + 1 >= HOLD_LEN)
                    hold_done <= 1'b1;
            end
            else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("page_bitmap_allocator_top: mismatch");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_total(int unsigned t);
        apb_write(ADDR_TOTAL_PAGES, t);
        managed = (t < NPAGES) ? t : NPAGES;
    endtask

    task automatic drain();
        while (request_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(int unsigned n, int unsigned max_cnt);
        int unsigned b;
        int unsigned k;
        logic [1:0] op;
        for (int unsigned i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k < 4)
                op = OP_ALLOC;
            else if (k < 6)
                op = OP_FREE;
            else if (k < 7)
                op = OP_MARK;
            else
                op = OP_QUERY;
            if ($urandom_range(0, 3) == 0)
                b = $urandom_range(0, 4095);
            else
                b = $urandom_range(0, 255);
            k = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 8191)
                                             : $urandom_range(0, max_cnt);
            request_q.push_back(make_req(op, b, k));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_off = 1'b0;
        managed = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero pages managed: every allocate fails
        request_q.push_back(make_req(OP_ALLOC, 0, 1));
        request_q.push_back(make_req(OP_QUERY, 0, 0));
        request_q.push_back(make_req(OP_MARK, 4095, 8191));
        request_q.push_back(make_req(OP_QUERY, 4094, 2));
        request_q.push_back(make_req(OP_FREE, 4095, 1));
        drain();

        set_total(8191);
        request_q.push_back(make_req(OP_ALLOC, 0, 0));
        request_q.push_back(make_req(OP_ALLOC, 0, 4097));
        request_q.push_back(make_req(OP_ALLOC, 0, 4096));
        request_q.push_back(make_req(OP_QUERY, 2048, 8));
        request_q.push_back(make_req(OP_ALLOC, 0, 1));
        request_q.push_back(make_req(OP_FREE, 0, 4096));
        request_q.push_back(make_req(OP_MARK, 1, 2));
        request_q.push_back(make_req(OP_ALLOC, 0, 1));
        request_q.push_back(make_req(OP_ALLOC, 0, 2));
        request_q.push_back(make_req(OP_MARK, 0, 1));
        request_q.push_back(make_req(OP_FREE, 2, 1));
        request_q.push_back(make_req(OP_ALLOC, 0, 1));
        request_q.push_back(make_req(OP_QUERY, 100, 10));
        request_q.push_back(make_req(OP_FREE, 0, 8191));
        drain();

        // tight map: last start position is usable
        set_total(16);
        request_q.push_back(make_req(OP_MARK, 3, 1));
        request_q.push_back(make_req(OP_ALLOC, 0, 12));
        request_q.push_back(make_req(OP_ALLOC, 0, 1));
        request_q.push_back(make_req(OP_ALLOC, 0, 4));
        request_q.push_back(make_req(OP_FREE, 0, 16));
        random_phase(120, 8);
        // receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        wait (hold_done);
        hold_off = 1'b0;
        drain();

        set_total(64);
        random_phase(150, 16);
        drain();
        set_total(256);
        random_phase(150, 40);
        drain();
        set_total(4096);
        random_phase(60, 64);
        drain();

        $display("%0d items checked over totals 0..8191 incl. stalls, %0d failed allocations",
                 n_checked, n_alloc_fail);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("page_bitmap_allocator_top: match");
        else
            $display("page_bitmap_allocator_top: mismatch");
        $finish;
    end
endmodule
